// ----- hw/rtl/idfcp_pkg.sv -----
// shared types and constants for the identifier frame packer
package idfcp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hA5;
    localparam logic [7:0] ADDR_BYTE = 8'h00;
    localparam logic [7:0] PAD_BYTE  = 8'h00;
    localparam logic [7:0] FTR_BYTE  = 8'hD5;
    localparam logic [8:0] CHK_BASE  = 9'h100;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic frame_go;
        logic last_byte;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/idfcp_if.sv -----
// character and frame byte channel interfaces
interface idfcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] id_char;
    logic       last_char;

    modport source (output valid, output id_char, output last_char, input ready);
    modport sink   (input valid, input id_char, input last_char, output ready);
endinterface

interface idfcp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [4:0] byte_position;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_byte, output ready);
endinterface

// ----- hw/rtl/idfcp_ctrl.sv -----
// controller: load and emit sequencing
module idfcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  idfcp_pkg::t_sts   i_sts,
    output idfcp_pkg::t_cmd   o_cmd
);

    idfcp_pkg::t_state r_state;
    idfcp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idfcp_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            idfcp_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.frame_go) begin
                        n_state = idfcp_pkg::ST_EMIT;
                    end
                end
            end
            idfcp_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_byte) begin
                        n_state = idfcp_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = idfcp_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ----- hw/rtl/idfcp_dp.sv -----
// datapath: character store, running sum, frame byte select and output register
module idfcp_dp #(
    parameter int unsigned MAX_ID_CHARS = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_id_char,
    input  logic            i_last_char,
    input  idfcp_pkg::t_cmd i_cmd,
    output idfcp_pkg::t_sts o_sts,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_frame_byte,
    output logic [4:0]      o_byte_position,
    output logic            o_last_byte
);

    localparam int unsigned CNT_W = $clog2(MAX_ID_CHARS + 1);
    localparam int unsigned POS_W = $clog2(MAX_ID_CHARS + 7);
    localparam int unsigned IDX_W = (MAX_ID_CHARS > 1) ? $clog2(MAX_ID_CHARS) : 1;

    logic [7:0]        r_store [MAX_ID_CHARS];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [7:0]        r_sum;
    logic              r_ended;
    logic [POS_W-1:0]  r_pos;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [4:0]        r_out_pos;
    logic              r_out_last;

    logic              w_store_en;
    logic [POS_W-1:0]  w_cnt_p;
    logic [POS_W-1:0]  w_rel;
    logic [IDX_W-1:0]  w_idx;
    logic [7:0]        w_total;
    logic [7:0]        w_chk;
    logic [7:0]        w_byte;
    logic              w_last;
    logic              w_out_free;

    // a character is stored while the identifier is open and there is room
    assign w_store_en = i_cmd.accept && !r_ended && (i_id_char != 8'h00)
                        && (r_count < CNT_W'(MAX_ID_CHARS));
    assign n_count    = w_store_en ? r_count + CNT_W'(1) : r_count;

    assign w_cnt_p = POS_W'(r_count);
    assign w_rel   = r_pos - POS_W'(4);
    assign w_idx   = w_rel[IDX_W-1:0];
    assign w_last  = (r_pos == w_cnt_p + POS_W'(6));

    // sum runs from the length byte to the end of the frame
    assign w_total = r_sum + 8'(r_count) + idfcp_pkg::FTR_BYTE;
    assign w_chk   = 8'(idfcp_pkg::CHK_BASE - {1'b0, w_total});

    always_comb begin
        if (r_pos == POS_W'(0)) begin
            w_byte = idfcp_pkg::HDR_BYTE;
        end else if (r_pos == POS_W'(1)) begin
            w_byte = idfcp_pkg::ADDR_BYTE;
        end else if (r_pos == POS_W'(2)) begin
            w_byte = w_chk;
        end else if (r_pos == POS_W'(3)) begin
            w_byte = 8'(r_count);
        end else if (r_pos < w_cnt_p + POS_W'(4)) begin
            w_byte = r_store[w_idx];
        end else if (r_pos == w_cnt_p + POS_W'(5)) begin
            w_byte = idfcp_pkg::FTR_BYTE;
        end else begin
            w_byte = idfcp_pkg::PAD_BYTE;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.frame_go  = i_last_char && (n_count != '0);
    assign o_sts.last_byte = w_last;
    assign o_sts.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_store[r_count[IDX_W-1:0]] <= i_id_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= 8'h00;
            r_ended     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_count <= n_count;
                if (w_store_en) begin
                    r_sum <= r_sum + i_id_char;
                end
                if (i_last_char) begin
                    r_ended <= 1'b0;
                end else if (i_id_char == 8'h00) begin
                    r_ended <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_pos   <= '0;
                    r_count <= '0;
                    r_sum   <= 8'h00;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= w_byte;
            r_out_pos  <= 5'(r_pos);
            r_out_last <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_last_byte     = r_out_last;

endmodule

// ----- hw/rtl/id_frame_checksum_packer_unit.sv -----
// top level of the identifier frame packer
//
//  channel  dir  payload                                   handshake
//  i_char   in   id_char[7:0], last_char                   valid / ready
//  o_frame  out  frame_byte[7:0], byte_position[4:0], last_byte   valid / ready
//
//  one character is taken per cycle while loading
//  a character marked last with a non-empty identifier starts emission of
//  count + 7 bytes, one per cycle from the byte select into the output register
//  no character is taken during emission; a stall on o_frame holds it
//  synchronous active-low reset clears count, sum, end flag and state
module id_frame_checksum_packer_unit #(
    parameter int unsigned MAX_ID_CHARS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    idfcp_in_if.sink             i_char,
    idfcp_out_if.source          o_frame
);

    idfcp_pkg::t_cmd w_cmd;
    idfcp_pkg::t_sts w_sts;
    logic            w_in_ready;

    assign i_char.ready = w_in_ready;

    idfcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    idfcp_dp #(
        .MAX_ID_CHARS (MAX_ID_CHARS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_id_char       (i_char.id_char),
        .i_last_char     (i_char.last_char),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_frame.valid),
        .i_out_ready     (o_frame.ready),
        .o_frame_byte    (o_frame.frame_byte),
        .o_byte_position (o_frame.byte_position),
        .o_last_byte     (o_frame.last_byte)
    );

endmodule

// ----- tb/id_frame_checksum_packer_unit_tb.sv -----
// testbench for the identifier frame packer: directed table plus random identifiers
`timescale 1ns / 1ps

module id_frame_checksum_packer_unit_tb;

    localparam int unsigned MAX_ID_CHARS = 11;
    localparam int          N_ITEMS      = 470;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [7:0] data;
        logic [4:0] pos;
        logic       last;
    } t_frame_beat;

    // one row of the directed table; typed rows carry the identifier length and checksum
    typedef struct {
        logic [7:0] ch;
        logic       lst;
        bit         typed;
        int         len;
        logic [7:0] chk;
    } t_char_row;

    logic i_clk;
    logic i_rst_n;

    idfcp_in_if  char_if ();
    idfcp_out_if frame_if ();

    id_frame_checksum_packer_unit #(
        .MAX_ID_CHARS(MAX_ID_CHARS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (char_if),
        .o_frame(frame_if)
    );

    // predictor state
    logic [7:0]  id_chars [MAX_ID_CHARS];
    int unsigned id_count;
    bit          id_ended;
    t_frame_beat frame_exp_q [$];

    // payload side info, changes together with the character
    bit          cur_typed;
    int          cur_len;
    logic [7:0]  cur_chk;

    int          err_count;
    int          cycle_count;
    int          items_sent;
    int          burst_left;
    int          rdy_mode;
    int          rdy_hold;
    t_frame_beat got_beat;
    t_frame_beat want_beat;
    t_char_row   dir_rows [$];

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("id_frame_checksum_packer_unit_tb NOT OK");
            $finish;
        end
    end

    // updates the identifier state for one accepted character and queues the frame it closes
    task automatic absorb_char(input logic [7:0] ch, input logic lst, input bit typed,
                               input int len, input logic [7:0] tchk);
        logic [7:0]  fb [18];
        logic [7:0]  sum;
        logic [8:0]  chk9;
        logic [7:0]  chk;
        int unsigned n;
        int          nb;
        if (!id_ended) begin
            if (ch == 8'h00) begin
                id_ended = 1'b1;
            end else if (id_count < MAX_ID_CHARS) begin
                id_chars[id_count] = ch;
                id_count++;
            end
        end
        if (lst) begin
            n = typed ? len : id_count;
            if (n > 0) begin
                sum = n[7:0] + idfcp_pkg::FTR_BYTE + idfcp_pkg::PAD_BYTE
                      + idfcp_pkg::PAD_BYTE;
                for (int i = 0; i < n; i++) sum = sum + id_chars[i];
                chk9 = idfcp_pkg::CHK_BASE - {1'b0, sum};
                chk  = typed ? tchk : chk9[7:0];
                fb[0] = idfcp_pkg::HDR_BYTE;
                fb[1] = idfcp_pkg::ADDR_BYTE;
                fb[2] = chk;
                fb[3] = n[7:0];
                for (int i = 0; i < n; i++) fb[4 + i] = id_chars[i];
                fb[4 + n] = idfcp_pkg::PAD_BYTE;
                fb[5 + n] = idfcp_pkg::FTR_BYTE;
                fb[6 + n] = idfcp_pkg::PAD_BYTE;
                nb = n + 7;
                for (int k = 0; k < nb; k++)
                    frame_exp_q.push_back('{fb[k], k[4:0], (k == nb - 1)});
            end
            id_count = 0;
            id_ended = 1'b0;
        end
    endtask

    // input transfers are predicted before output transfers of the same edge are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_if.valid && char_if.ready)
                absorb_char(char_if.id_char, char_if.last_char, cur_typed, cur_len, cur_chk);
            if (frame_if.valid && frame_if.ready) begin
                got_beat = '{frame_if.frame_byte, frame_if.byte_position, frame_if.last_byte};
                if (frame_exp_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected frame byte %h pos %0d last %b", $time,
                             got_beat.data, got_beat.pos, got_beat.last);
                end else begin
                    want_beat = frame_exp_q.pop_front();
                    if (got_beat.data !== want_beat.data || got_beat.pos !== want_beat.pos ||
                        got_beat.last !== want_beat.last) begin
                        err_count++;
                        $display("%0t: expected byte %h pos %0d last %b, got %h pos %0d last %b",
                                 $time, want_beat.data, want_beat.pos, want_beat.last,
                                 got_beat.data, got_beat.pos, got_beat.last);
                    end
                end
            end
        end
    end

    // receiver stalls in modes that each hold for a random stretch
    always @(negedge i_clk) begin
        if (rdy_hold == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_hold = $urandom_range(8, 80);
        end
        rdy_hold--;
        case (rdy_mode)
            0: begin
                frame_if.ready = 1'b1;
            end
            1: begin
                frame_if.ready = ($urandom_range(0, 1) == 1);
            end
            2: begin
                frame_if.ready = ($urandom_range(0, 3) != 0);
            end
            default: begin
                frame_if.ready = ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    // sender works in bursts; valid stays up across back-to-back transfers
    task automatic send_char(input logic [7:0] ch, input logic lst, input bit typed = 1'b0,
                             input int len = 0, input logic [7:0] chk = 8'h00);
        if (burst_left <= 0) begin
            char_if.valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        char_if.id_char   = ch;
        char_if.last_char = lst;
        cur_typed         = typed;
        cur_len           = len;
        cur_chk           = chk;
        char_if.valid     = 1'b1;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_frames_drained();
        char_if.valid = 1'b0;
        burst_left    = 0;
        while (frame_exp_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int id_len;
        int style;
        int n_noise;
        bit drained_mid;
        i_rst_n           = 1'b0;
        char_if.valid     = 1'b0;
        char_if.id_char   = 8'h00;
        char_if.last_char = 1'b0;
        frame_if.ready    = 1'b1;
        cur_typed         = 1'b0;
        cur_len           = 0;
        cur_chk           = 8'h00;
        id_count          = 0;
        id_ended          = 1'b0;
        drained_mid       = 1'b0;
        for (int i = 0; i < MAX_ID_CHARS; i++) id_chars[i] = 8'h00;

        // empty identifier straight after reset
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 0, 8'h00});
        dir_rows.push_back('{8'h01, 1'b1, 1'b1, 1, 8'h29});
        dir_rows.push_back('{8'hFF, 1'b1, 1'b1, 1, 8'h2B});
        // terminator on the last character
        dir_rows.push_back('{8'h80, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 1, 8'hAA});
        // characters after the terminator are dropped
        dir_rows.push_back('{8'h41, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'h00, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'h42, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'h43, 1'b1, 1'b1, 1, 8'hE9});
        dir_rows.push_back('{8'h55, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'hAA, 1'b1, 1'b1, 2, 8'h2A});
        // twelve characters, only eleven kept
        for (int i = 0; i < 11; i++) dir_rows.push_back('{8'hFF, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'hFF, 1'b1, 1'b1, 11, 8'h2B});
        // terminator then an empty last character
        dir_rows.push_back('{8'h00, 1'b0, 1'b0, 0, 8'h00});
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 0, 8'h00});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_char(dir_rows[r].ch, dir_rows[r].lst, dir_rows[r].typed,
                      dir_rows[r].len, dir_rows[r].chk);
        wait_frames_drained();

        while (items_sent < N_ITEMS) begin
            style = $urandom_range(0, 9);
            if (style < 7) begin
                id_len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 16)
                                                     : $urandom_range(1, 11);
                for (int i = 0; i < id_len - 1; i++)
                    send_char(8'($urandom_range(1, 255)), 1'b0);
                case ($urandom_range(0, 2))
                    0: begin
                        send_char(8'($urandom_range(1, 255)), 1'b1);
                    end
                    1: begin
                        send_char(8'($urandom_range(1, 255)), 1'b0);
                        send_char(8'h00, 1'b1);
                    end
                    default: begin
                        send_char(8'($urandom_range(1, 255)), 1'b0);
                        send_char(8'h00, 1'b0);
                        repeat ($urandom_range(0, 3))
                            send_char(8'($urandom_range(0, 255)), 1'b0);
                        send_char(8'($urandom_range(0, 255)), 1'b1);
                    end
                endcase
            end else if (style == 7) begin
                send_char(8'h00, 1'b1);
            end else begin
                n_noise = $urandom_range(1, 8);
                repeat (n_noise)
                    send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
            end
            // sender holds off once until the output side has caught up
            if (!drained_mid && items_sent > N_ITEMS / 2) begin
                wait_frames_drained();
                drained_mid = 1'b1;
            end
        end
        // close any open identifier so its frame is checked too
        send_char(8'($urandom_range(1, 255)), 1'b1);

        wait_frames_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && frame_exp_q.size() == 0) begin
            $display("id_frame_checksum_packer_unit_tb OK");
        end else begin
            $display("id_frame_checksum_packer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
